>>> rtl/rlt_pkg.sv
// Shared types, token codes and character helpers for the rule tokenizer.
`default_nettype none
package rlt_pkg;

	localparam int SIZE_DIGITS_MAX = 9;
	localparam int KW_COUNT = 14;

	localparam logic [5:0] K_LPAREN  = 6'd0;
	localparam logic [5:0] K_RPAREN  = 6'd1;
	localparam logic [5:0] K_LBRACE  = 6'd2;
	localparam logic [5:0] K_RBRACE  = 6'd3;
	localparam logic [5:0] K_COLON   = 6'd4;
	localparam logic [5:0] K_DOLLAR  = 6'd5;
	localparam logic [5:0] K_ASSIGN  = 6'd6;
	localparam logic [5:0] K_LT      = 6'd8;
	localparam logic [5:0] K_GT      = 6'd10;
	localparam logic [5:0] K_STAR    = 6'd12;
	localparam logic [5:0] K_STRING  = 6'd13;
	localparam logic [5:0] K_BYTESEQ = 6'd14;
	localparam logic [5:0] K_REGEXP  = 6'd15;
	localparam logic [5:0] K_INTEGER = 6'd16;
	localparam logic [5:0] K_IDENT   = 6'd17;
	localparam logic [5:0] K_DOLLVAR = 6'd18;
	localparam logic [5:0] K_STARVAR = 6'd19;
	localparam logic [5:0] K_KW_BASE = 6'd20;
	localparam logic [5:0] K_HEXBYTE = 6'd34;
	localparam logic [5:0] K_ERROR   = 6'd35;

	localparam logic [2:0] E_NONE       = 3'd0;
	localparam logic [2:0] E_UNKNOWN    = 3'd1;
	localparam logic [2:0] E_SIZE       = 3'd2;
	localparam logic [2:0] E_HEX        = 3'd3;
	localparam logic [2:0] E_SPANS_LINE = 3'd4;
	localparam logic [2:0] E_UNTERM     = 3'd5;

	// keyword text right-aligned, zero padded; buffer shifts characters in at the low end
	localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
		72'("rule"), 72'("meta"), 72'("condition"), 72'("content"), 72'("and"),
		72'("or"), 72'("nocase"), 72'("ascii"), 72'("wide"), 72'("of"),
		72'("them"), 72'("any"), 72'("all"), 72'("at")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd4, 4'd4, 4'd9, 4'd7, 4'd3, 4'd2, 4'd6, 4'd5, 4'd4, 4'd2, 4'd4, 4'd3, 4'd3, 4'd2
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start_pos;
		logic [15:0] end_pos;
		logic [15:0] line_number;
		logic [63:0] value;
		logic [2:0]  error_code;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} batch_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} kw_hit_t;

	function automatic result_t mk_res(input logic [5:0] kind, input logic [15:0] s,
			input logic [15:0] e, input logic [15:0] line, input logic [63:0] v,
			input logic [2:0] err);
		result_t r;
		r.kind = kind;
		r.start_pos = s;
		r.end_pos = e;
		r.line_number = line;
		r.value = v;
		r.error_code = err;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic kw_hit_t kw_lookup(input logic [71:0] buf_v, input logic [3:0] len);
		kw_hit_t h;
		h.hit = 1'b0;
		h.idx = 4'd0;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (!h.hit && len == KW_LEN[i] && buf_v == KW_TEXT[i]) begin
				h.hit = 1'b1;
				h.idx = 4'(i);
			end
		end
		return h;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	// bit 4 set means not a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (is_digit(c)) begin
			t = c - 8'h30;
		end else if (c >= "a" && c <= "f") begin
			t = c - 8'h57;
		end else if (c >= "A" && c <= "F") begin
			t = c - 8'h37;
		end else begin
			t = 8'h10;
		end
		return t[4:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/rlt_scanner.sv
// Scanner state and per-item token logic; produces up to two results per item.
`default_nettype none
module rlt_scanner #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              action,
	input  wire logic [7:0]        ch,
	input  wire logic              cfg_we,
	input  wire logic [15:0]       cfg_data,
	output rlt_pkg::batch_t        batch
);

	localparam int PB = POSITION_BITS;

	typedef enum logic [2:0] {
		M_IDLE, M_OP, M_IDENT, M_INT, M_SIZEB, M_STR, M_REGEX, M_HEX
	} mode_t;

	mode_t          mode_q, mode_d;
	logic [7:0]     pend_q, pend_d;
	logic [7:0]     prev_q, prev_d;
	logic [PB-1:0]  pos_q, pos_d;
	logic [PB-1:0]  tstart_q, tstart_d;
	logic [15:0]    first_line_q;
	logic [15:0]    line_q, line_d;
	logic [15:0]    sec_line_q, sec_line_d;
	logic [71:0]    kw_q, kw_d;
	logic [3:0]     idlen_q, idlen_d;
	logic [63:0]    acc_q, acc_d;
	logic [29:0]    sdig_q, sdig_d;
	logic [3:0]     dcnt_q, dcnt_d;
	logic [1:0]     sletter_q, sletter_d;
	logic [3:0]     hnib_q, hnib_d;
	logic           nphase_q, nphase_d;
	logic [15:0]    bcnt_q, bcnt_d;
	logic [PB-1:0]  fcp_q, fcp_d;
	logic [PB-1:0]  lcp_q, lcp_d;
	logic           halted_q, halted_d;

	logic [15:0]    pos16, pos1_16, ts16, ts1_16, lcp1_16, fcp16;
	logic [PB:0]    pos1_w, ts1_w, lcp1_w;
	logic [67:0]    acc_prod;
	logic [29:0]    sdig_next;
	logic [3:0]     dig;
	logic [4:0]     hv;
	logic [5:0]     op_base;
	logic [59:0]    scaled;
	rlt_pkg::kw_hit_t kwh;

	always_comb begin
		pos1_w  = {1'b0, pos_q} + 1'b1;
		ts1_w   = {1'b0, tstart_q} + 1'b1;
		lcp1_w  = {1'b0, lcp_q} + 1'b1;
		pos16   = 16'(pos_q);
		pos1_16 = 16'(pos1_w);
		ts16    = 16'(tstart_q);
		ts1_16  = 16'(ts1_w);
		lcp1_16 = 16'(lcp1_w);
		fcp16   = 16'(fcp_q);
		dig     = 4'(ch - 8'h30);
		acc_prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 68'(dig);
		sdig_next = 30'((sdig_q << 3) + (sdig_q << 1) + 30'(dig));
		hv      = rlt_pkg::hex_val(ch);
		op_base = (pend_q == "=") ? rlt_pkg::K_ASSIGN
			: (pend_q == "<") ? rlt_pkg::K_LT : rlt_pkg::K_GT;
		scaled  = 60'(sdig_q) << (5'd10 * 5'(sletter_q));
		kwh     = rlt_pkg::kw_lookup(kw_q, idlen_q);
	end

	always_comb begin
		rlt_pkg::result_t ra, rb;
		logic has_a, has_b, taken, in_section;

		mode_d = mode_q; pend_d = pend_q; prev_d = prev_q; pos_d = pos_q;
		tstart_d = tstart_q; line_d = line_q; sec_line_d = sec_line_q;
		kw_d = kw_q; idlen_d = idlen_q; acc_d = acc_q; sdig_d = sdig_q;
		dcnt_d = dcnt_q; sletter_d = sletter_q; hnib_d = hnib_q; nphase_d = nphase_q;
		bcnt_d = bcnt_q; fcp_d = fcp_q; lcp_d = lcp_q; halted_d = halted_q;
		ra = '0; rb = '0; has_a = 1'b0; has_b = 1'b0; taken = 1'b0;
		in_section = (mode_q == M_STR) || (mode_q == M_REGEX);

		if (action) begin
			if (!halted_q) begin
				unique case (mode_q)
					M_OP: begin
						ra = rlt_pkg::mk_res(op_base, ts16, ts1_16, line_q, '0, rlt_pkg::E_NONE);
						has_a = 1'b1;
					end
					M_IDENT: begin
						has_a = 1'b1;
						if (kwh.hit) begin
							ra = rlt_pkg::mk_res(rlt_pkg::K_KW_BASE + 6'(kwh.idx), ts16, pos16,
								line_q, '0, rlt_pkg::E_NONE);
						end else begin
							ra = rlt_pkg::mk_res((pend_q != 8'd0) ? rlt_pkg::K_DOLLVAR
								: rlt_pkg::K_IDENT, ts16, pos16, line_q, '0, rlt_pkg::E_NONE);
						end
					end
					M_INT: begin
						ra = rlt_pkg::mk_res(rlt_pkg::K_INTEGER, ts16, pos16, line_q, acc_q,
							rlt_pkg::E_NONE);
						has_a = 1'b1;
					end
					M_SIZEB: begin
						ra = rlt_pkg::mk_res(rlt_pkg::K_ERROR, ts16, pos16, line_q, '0,
							rlt_pkg::E_SIZE);
						has_a = 1'b1;
					end
					M_STR, M_REGEX, M_HEX: begin
						ra = rlt_pkg::mk_res(rlt_pkg::K_ERROR, ts16, pos16, line_q, '0,
							rlt_pkg::E_UNTERM);
						has_a = 1'b1;
					end
					default: ;
				endcase
			end
			mode_d = M_IDLE; pend_d = '0; prev_d = '0; pos_d = '0; tstart_d = '0;
			line_d = first_line_q; sec_line_d = '0; kw_d = '0; idlen_d = '0;
			acc_d = '0; sdig_d = '0; dcnt_d = '0; sletter_d = '0; hnib_d = '0;
			nphase_d = 1'b0; bcnt_d = '0; fcp_d = '0; lcp_d = '0; halted_d = 1'b0;
		end else if (!halted_q) begin
			unique case (mode_q)
				M_OP: begin
					has_a = 1'b1;
					if (ch == "=") begin
						ra = rlt_pkg::mk_res(op_base + 6'd1, ts16, pos1_16, line_q, '0,
							rlt_pkg::E_NONE);
						taken = 1'b1;
					end else begin
						ra = rlt_pkg::mk_res(op_base, ts16, ts1_16, line_q, '0, rlt_pkg::E_NONE);
					end
					mode_d = M_IDLE;
				end
				M_IDENT: begin
					if (rlt_pkg::is_alpha(ch) || rlt_pkg::is_digit(ch)) begin
						if (idlen_q < 4'd9) kw_d = {kw_q[63:0], ch};
						if (idlen_q < 4'd10) idlen_d = idlen_q + 4'd1;
						taken = 1'b1;
					end else begin
						has_a = 1'b1;
						if (kwh.hit) begin
							ra = rlt_pkg::mk_res(rlt_pkg::K_KW_BASE + 6'(kwh.idx), ts16, pos16,
								line_q, '0, rlt_pkg::E_NONE);
						end else if (ch == "*") begin
							ra = rlt_pkg::mk_res(rlt_pkg::K_STARVAR, ts16, pos16, line_q, '0,
								rlt_pkg::E_NONE);
							taken = 1'b1;
						end else begin
							ra = rlt_pkg::mk_res((pend_q != 8'd0) ? rlt_pkg::K_DOLLVAR
								: rlt_pkg::K_IDENT, ts16, pos16, line_q, '0, rlt_pkg::E_NONE);
						end
						mode_d = M_IDLE;
					end
				end
				M_INT: begin
					if (rlt_pkg::is_digit(ch)) begin
						acc_d = (acc_prod[67:64] != 4'd0) ? '1 : acc_prod[63:0];
						if (dcnt_q < 4'(rlt_pkg::SIZE_DIGITS_MAX)) begin
							sdig_d = sdig_next;
							dcnt_d = dcnt_q + 4'd1;
						end
						taken = 1'b1;
					end else if (rlt_pkg::is_alpha(ch)) begin
						taken = 1'b1;
						if (ch == "B" || ch == "b") begin
							ra = rlt_pkg::mk_res(rlt_pkg::K_INTEGER, ts16, pos1_16, line_q,
								64'(sdig_q), rlt_pkg::E_NONE);
							has_a = 1'b1;
							mode_d = M_IDLE;
						end else if (ch == "K" || ch == "k") begin
							sletter_d = 2'd1; mode_d = M_SIZEB;
						end else if (ch == "M" || ch == "m") begin
							sletter_d = 2'd2; mode_d = M_SIZEB;
						end else if (ch == "G" || ch == "g") begin
							sletter_d = 2'd3; mode_d = M_SIZEB;
						end else begin
							ra = rlt_pkg::mk_res(rlt_pkg::K_ERROR, ts16, pos16, line_q, '0,
								rlt_pkg::E_SIZE);
							has_a = 1'b1; halted_d = 1'b1; mode_d = M_IDLE;
						end
					end else begin
						ra = rlt_pkg::mk_res(rlt_pkg::K_INTEGER, ts16, pos16, line_q, acc_q,
							rlt_pkg::E_NONE);
						has_a = 1'b1;
						mode_d = M_IDLE;
					end
				end
				M_SIZEB: begin
					has_a = 1'b1;
					taken = 1'b1;
					mode_d = M_IDLE;
					if (ch == "B" || ch == "b") begin
						ra = rlt_pkg::mk_res(rlt_pkg::K_INTEGER, ts16, pos1_16, line_q,
							64'(scaled), rlt_pkg::E_NONE);
					end else begin
						ra = rlt_pkg::mk_res(rlt_pkg::K_ERROR, ts16, pos16, line_q, '0,
							rlt_pkg::E_SIZE);
						halted_d = 1'b1;
					end
				end
				M_STR: begin
					taken = 1'b1;
					if (ch == "\"" && prev_q != "\\") begin
						ra = rlt_pkg::mk_res(rlt_pkg::K_STRING, ts1_16, pos16, line_q, '0,
							rlt_pkg::E_NONE);
						has_a = 1'b1;
						mode_d = M_IDLE;
					end else if (ch == 8'h0a) begin
						ra = rlt_pkg::mk_res(rlt_pkg::K_ERROR, ts16, pos16, sec_line_q, '0,
							rlt_pkg::E_SPANS_LINE);
						has_a = 1'b1; halted_d = 1'b1; mode_d = M_IDLE;
					end
				end
				M_REGEX: begin
					taken = 1'b1;
					if (ch == "/" && prev_q != "\\") begin
						ra = rlt_pkg::mk_res(rlt_pkg::K_REGEXP, ts16, pos1_16, line_q, '0,
							rlt_pkg::E_NONE);
						has_a = 1'b1;
						mode_d = M_IDLE;
					end else if (ch == 8'h0a) begin
						line_d = line_q + 16'd1;
					end
				end
				M_HEX: begin
					taken = 1'b1;
					if (ch == "|") begin
						has_a = 1'b1;
						if (bcnt_q != 16'd0 || nphase_q) begin
							ra = rlt_pkg::mk_res(rlt_pkg::K_BYTESEQ, fcp16, lcp1_16, line_q,
								64'(bcnt_q), rlt_pkg::E_NONE);
						end else begin
							ra = rlt_pkg::mk_res(rlt_pkg::K_BYTESEQ, pos16, pos16, line_q,
								64'(bcnt_q), rlt_pkg::E_NONE);
						end
						mode_d = M_IDLE;
					end else if (ch == " ") begin
						taken = 1'b1;
					end else if (hv[4]) begin
						ra = rlt_pkg::mk_res(rlt_pkg::K_ERROR, pos16, pos1_16, line_q, '0,
							rlt_pkg::E_HEX);
						has_a = 1'b1; halted_d = 1'b1; mode_d = M_IDLE;
					end else begin
						if (bcnt_q == 16'd0 && !nphase_q) fcp_d = pos_q;
						if (!nphase_q) begin
							hnib_d = hv[3:0];
							nphase_d = 1'b1;
						end else begin
							ra = rlt_pkg::mk_res(rlt_pkg::K_HEXBYTE, 16'(lcp_q), pos1_16, line_q,
								64'({hnib_q, hv[3:0]}), rlt_pkg::E_NONE);
							has_a = 1'b1;
							nphase_d = 1'b0;
							if (bcnt_q != 16'hffff) bcnt_d = bcnt_q + 16'd1;
						end
						lcp_d = pos_q;
					end
				end
				default: ;
			endcase

			if (!taken && !halted_d) begin
				tstart_d = pos_q;
				has_b = 1'b1;
				rb = rlt_pkg::mk_res(rlt_pkg::K_LPAREN, pos16, pos1_16, line_q, '0,
					rlt_pkg::E_NONE);
				priority if (ch == "(") begin
					rb.kind = rlt_pkg::K_LPAREN;
				end else if (ch == ")") begin
					rb.kind = rlt_pkg::K_RPAREN;
				end else if (ch == "{") begin
					rb.kind = rlt_pkg::K_LBRACE;
				end else if (ch == "}") begin
					rb.kind = rlt_pkg::K_RBRACE;
				end else if (ch == ":") begin
					rb.kind = rlt_pkg::K_COLON;
				end else if (ch == "$") begin
					rb.kind = rlt_pkg::K_DOLLAR;
				end else if (ch == "*") begin
					rb.kind = rlt_pkg::K_STAR;
				end else if (ch == "=" || ch == "<" || ch == ">") begin
					has_b = 1'b0; pend_d = ch; mode_d = M_OP;
				end else if (ch == " " || ch == 8'h09 || ch == 8'h0d || ch == 8'h00) begin
					has_b = 1'b0;
				end else if (ch == 8'h0a) begin
					has_b = 1'b0; line_d = line_q + 16'd1;
				end else if (ch == "\"") begin
					has_b = 1'b0; sec_line_d = line_q; mode_d = M_STR;
				end else if (ch == "/") begin
					has_b = 1'b0; mode_d = M_REGEX;
				end else if (ch == "|") begin
					has_b = 1'b0; bcnt_d = '0; nphase_d = 1'b0; hnib_d = '0;
					fcp_d = '0; lcp_d = '0; mode_d = M_HEX;
				end else if (rlt_pkg::is_digit(ch)) begin
					has_b = 1'b0; acc_d = 64'(dig); sdig_d = 30'(dig); dcnt_d = 4'd1;
					mode_d = M_INT;
				end else if (rlt_pkg::is_alpha(ch)) begin
					has_b = 1'b0; pend_d = (prev_q == "$") ? 8'd1 : 8'd0;
					kw_d = {64'd0, ch}; idlen_d = 4'd1; mode_d = M_IDENT;
				end else begin
					rb.kind = rlt_pkg::K_ERROR;
					rb.error_code = rlt_pkg::E_UNKNOWN;
					halted_d = 1'b1;
					mode_d = M_IDLE;
				end
			end

			if (!halted_d) begin
				prev_d = (in_section && ch == "\\" && prev_q == "\\") ? 8'd0 : ch;
				pos_d = pos1_w[PB-1:0];
			end
		end

		batch.count = 2'(has_a) + 2'(has_b);
		batch.r0 = has_a ? ra : rb;
		batch.r1 = rb;
		if (has_a && has_b) begin
			batch.r1.last = 1'b1;
		end else begin
			batch.r0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pend_q <= '0; prev_q <= '0; pos_q <= '0; tstart_q <= '0;
			first_line_q <= 16'd1; line_q <= 16'd1; sec_line_q <= '0; kw_q <= '0;
			idlen_q <= '0; acc_q <= '0; sdig_q <= '0; dcnt_q <= '0; sletter_q <= '0;
			hnib_q <= '0; nphase_q <= 1'b0; bcnt_q <= '0; fcp_q <= '0; lcp_q <= '0;
			halted_q <= 1'b0;
		end else begin
			if (step) begin
				mode_q <= mode_d; pend_q <= pend_d; prev_q <= prev_d; pos_q <= pos_d;
				tstart_q <= tstart_d; sec_line_q <= sec_line_d;
				kw_q <= kw_d; idlen_q <= idlen_d; acc_q <= acc_d; sdig_q <= sdig_d;
				dcnt_q <= dcnt_d; sletter_q <= sletter_d; hnib_q <= hnib_d;
				nphase_q <= nphase_d; bcnt_q <= bcnt_d; fcp_q <= fcp_d; lcp_q <= lcp_d;
				halted_q <= halted_d;
			end
			if (cfg_we) begin
				first_line_q <= cfg_data;
				line_q <= cfg_data;
			end else if (step) begin
				line_q <= line_d;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/rlt_out_fifo.sv
// Four-entry result queue: takes up to two results a cycle, hands out one.
`default_nettype none
module rlt_out_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire rlt_pkg::batch_t wr_batch,
	output logic                 room2,
	output logic                 rd_valid,
	input  wire logic            rd_ready,
	output rlt_pkg::result_t     rd_data
);

	rlt_pkg::result_t mem_q [4];
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] cnt_q;
	logic [1:0] nwr;
	logic       rd;

	assign room2    = cnt_q <= 3'd2;
	assign rd_valid = cnt_q != 3'd0;
	assign rd_data  = mem_q[rptr_q];
	assign rd       = rd_valid && rd_ready;
	assign nwr      = wr_en ? wr_batch.count : 2'd0;

	always_ff @(posedge clk) begin
		if (nwr != 2'd0) mem_q[wptr_q] <= wr_batch.r0;
		if (nwr == 2'd2) mem_q[wptr_q + 2'd1] <= wr_batch.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wptr_q <= wptr_q + nwr;
			if (rd) rptr_q <= rptr_q + 2'd1;
			cnt_q <= cnt_q + 3'(nwr) - 3'(rd);
		end
	end

endmodule
`default_nettype wire

>>> rtl/rule_language_tokenizer.sv
// Tokenizer for a YARA-style rule language: one source byte in, tokens out.
// Takes one item per clock while the result queue has room for two results;
// each item updates the registered scanner state and its results
// (none, one or two) enter a four-entry queue, so a stalled output side
// holds off input only once three or more results are waiting. Results are
// queued behind any waiting results. The configuration write sets the first
// line number and reloads the line counter; it is always ready.
`default_nettype none
module rule_language_tokenizer #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [7:0]  ch,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       kind,
	output logic [15:0]      start_pos,
	output logic [15:0]      end_pos,
	output logic [15:0]      line_number,
	output logic [63:0]      value,
	output logic [2:0]       error_code,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	rlt_pkg::batch_t  batch;
	rlt_pkg::result_t head;
	logic             room2, step;

	assign in_ready  = room2;
	assign step      = in_valid && room2;
	assign cfg_ready = 1'b1;

	rlt_scanner #(.POSITION_BITS(POSITION_BITS)) u_scan (
		.clk(clk), .arst_n(arst_n), .step(step), .action(action), .ch(ch),
		.cfg_we(cfg_valid), .cfg_data(cfg_data), .batch(batch)
	);

	rlt_out_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(step), .wr_batch(batch), .room2(room2),
		.rd_valid(out_valid), .rd_ready(out_ready), .rd_data(head)
	);

	assign kind        = head.kind;
	assign start_pos   = head.start_pos;
	assign end_pos     = head.end_pos;
	assign line_number = head.line_number;
	assign value       = head.value;
	assign error_code  = head.error_code;
	assign last        = head.last;

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the rule language tokenizer: directed and random source streams.
`timescale 1ns / 1ps
module testbench;

	localparam int LIMIT = 400000;
	localparam logic [3:0] S_IDLE = 4'd0, S_OP = 4'd1, S_IDENT = 4'd2, S_INT = 4'd3,
		S_SIZEB = 4'd4, S_STR = 4'd5, S_REGEX = 4'd6, S_HEX = 4'd7;
	localparam logic ACT_CHAR = 1'b0, ACT_EOS = 1'b1;

	typedef struct packed {
		logic       act;
		logic [7:0] c;
	} src_item_t;

	typedef bit bool_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic [7:0] ch = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] kind;
	logic [15:0] start_pos, end_pos, line_number;
	logic [63:0] value;
	logic [2:0] error_code;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = 16'd0;

	rule_language_tokenizer DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .ch(ch),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .start_pos(start_pos), .end_pos(end_pos), .line_number(line_number),
		.value(value), .error_code(error_code), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [15:0] p_first_line;
	logic [3:0]  p_mode;
	logic [7:0]  p_op, p_prev;
	logic [15:0] p_pos, p_tstart, p_line, p_sec_line;
	logic [7:0]  p_kw [9];
	logic [3:0]  p_ilen;
	logic [63:0] p_acc, p_sdig;
	logic [3:0]  p_dcnt;
	logic [1:0]  p_letter;
	logic [3:0]  p_hnib;
	logic        p_phase;
	logic [15:0] p_bcnt, p_first_c, p_last_c;
	logic        p_halted;

	rlt_pkg::result_t tokens_due[$];
	rlt_pkg::result_t step_out[$];
	src_item_t src_pending[$];
	int mismatches = 0, cycles = 0, accepted = 0, tokens_seen = 0, errors_seen = 0;
	bool_t dummy;
	bit idle_free = 1'b0;
	bit hold_sender = 1'b0;

	function automatic bit lx_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic bit lx_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction
	function automatic int lx_hex(logic [7:0] c);
		if (lx_digit(c)) return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic void push_tok(logic [5:0] k, logic [15:0] s, logic [15:0] e,
			logic [15:0] ln, logic [63:0] v, logic [2:0] er);
		rlt_pkg::result_t r;
		r.kind = k; r.start_pos = s; r.end_pos = e; r.line_number = ln;
		r.value = v; r.error_code = er; r.last = 1'b0;
		if (step_out.size() < 2) step_out.insert(step_out.size(), r);
	endfunction

	function automatic void raise_err(logic [2:0] er, logic [15:0] s, logic [15:0] e,
			logic [15:0] ln);
		push_tok(rlt_pkg::K_ERROR, s, e, ln, 64'd0, er);
		p_halted = 1'b1;
		p_mode = S_IDLE;
	endfunction

	task automatic scanner_clear();
		p_mode = S_IDLE; p_op = '0; p_prev = '0; p_pos = '0; p_tstart = '0;
		p_line = p_first_line; p_sec_line = '0;
		for (int i = 0; i < 9; i++) p_kw[i] = '0;
		p_ilen = '0; p_acc = '0; p_sdig = '0; p_dcnt = '0; p_letter = '0;
		p_hnib = '0; p_phase = 1'b0; p_bcnt = '0; p_first_c = '0; p_last_c = '0;
		p_halted = 1'b0;
	endtask

	function automatic int kw_match();
		string kws[14] = '{"rule", "meta", "condition", "content", "and", "or", "nocase",
			"ascii", "wide", "of", "them", "any", "all", "at"};
		bit ok;
		for (int i = 0; i < 14; i++) begin
			if (p_ilen == kws[i].len()) begin
				ok = 1'b1;
				for (int j = 0; j < kws[i].len(); j++)
					if (p_kw[j] != kws[i][j]) ok = 1'b0;
				if (ok) return i;
			end
		end
		return -1;
	endfunction

	function automatic bit finish_ident(int c);
		int k;
		k = kw_match();
		if (k >= 0) begin
			push_tok(rlt_pkg::K_KW_BASE + 6'(k), p_tstart, p_pos, p_line, 64'd0,
				rlt_pkg::E_NONE);
			return 1'b0;
		end
		if (c == "*") begin
			push_tok(rlt_pkg::K_STARVAR, p_tstart, p_pos, p_line, 64'd0, rlt_pkg::E_NONE);
			return 1'b1;
		end
		push_tok(p_op != 0 ? rlt_pkg::K_DOLLVAR : rlt_pkg::K_IDENT, p_tstart, p_pos, p_line,
			64'd0, rlt_pkg::E_NONE);
		return 1'b0;
	endfunction

	function automatic bit finish_int(int c);
		if (c >= 0 && lx_alpha(8'(c))) begin
			if (c == "B" || c == "b") begin
				push_tok(rlt_pkg::K_INTEGER, p_tstart, p_pos + 16'd1, p_line, p_sdig,
					rlt_pkg::E_NONE);
				p_mode = S_IDLE;
			end else if (c == "K" || c == "k" || c == "M" || c == "m" || c == "G" || c == "g") begin
				p_letter = (c == "K" || c == "k") ? 2'd1 : (c == "M" || c == "m") ? 2'd2 : 2'd3;
				p_mode = S_SIZEB;
			end else begin
				raise_err(rlt_pkg::E_SIZE, p_tstart, p_pos, p_line);
			end
			return 1'b1;
		end
		push_tok(rlt_pkg::K_INTEGER, p_tstart, p_pos, p_line, p_acc, rlt_pkg::E_NONE);
		p_mode = S_IDLE;
		return 1'b0;
	endfunction

	function automatic logic [5:0] op_base();
		return p_op == "=" ? rlt_pkg::K_ASSIGN : p_op == "<" ? rlt_pkg::K_LT : rlt_pkg::K_GT;
	endfunction

	task automatic idle_char(logic [7:0] c);
		p_tstart = p_pos;
		case (c)
			"(": push_tok(rlt_pkg::K_LPAREN, p_pos, p_pos + 16'd1, p_line, 64'd0, rlt_pkg::E_NONE);
			")": push_tok(rlt_pkg::K_RPAREN, p_pos, p_pos + 16'd1, p_line, 64'd0, rlt_pkg::E_NONE);
			"{": push_tok(rlt_pkg::K_LBRACE, p_pos, p_pos + 16'd1, p_line, 64'd0, rlt_pkg::E_NONE);
			"}": push_tok(rlt_pkg::K_RBRACE, p_pos, p_pos + 16'd1, p_line, 64'd0, rlt_pkg::E_NONE);
			":": push_tok(rlt_pkg::K_COLON, p_pos, p_pos + 16'd1, p_line, 64'd0, rlt_pkg::E_NONE);
			"$": push_tok(rlt_pkg::K_DOLLAR, p_pos, p_pos + 16'd1, p_line, 64'd0, rlt_pkg::E_NONE);
			"*": push_tok(rlt_pkg::K_STAR, p_pos, p_pos + 16'd1, p_line, 64'd0, rlt_pkg::E_NONE);
			"=", "<", ">": begin
				p_op = c;
				p_mode = S_OP;
			end
			" ", "\t", 8'h0d, 8'h00: ;
			8'h0a: p_line = p_line + 16'd1;
			"\"": begin
				p_sec_line = p_line;
				p_mode = S_STR;
			end
			"/": p_mode = S_REGEX;
			"|": begin
				p_bcnt = '0; p_phase = 1'b0; p_hnib = '0; p_first_c = '0; p_last_c = '0;
				p_mode = S_HEX;
			end
			default: begin
				if (lx_digit(c)) begin
					p_acc = 64'(c - "0");
					p_sdig = 64'(c - "0");
					p_dcnt = 4'd1;
					p_mode = S_INT;
				end else if (lx_alpha(c)) begin
					p_op = (p_prev == "$") ? 8'd1 : 8'd0;
					for (int i = 0; i < 9; i++) p_kw[i] = '0;
					p_kw[0] = c;
					p_ilen = 4'd1;
					p_mode = S_IDENT;
				end else begin
					raise_err(rlt_pkg::E_UNKNOWN, p_pos, p_pos + 16'd1, p_line);
				end
			end
		endcase
	endtask

	task automatic hex_char(logic [7:0] c);
		bit seen;
		int v;
		seen = p_bcnt != 0 || p_phase != 0;
		if (c == "|") begin
			push_tok(rlt_pkg::K_BYTESEQ, seen ? p_first_c : p_pos,
				seen ? p_last_c + 16'd1 : p_pos, p_line, 64'(p_bcnt), rlt_pkg::E_NONE);
			p_mode = S_IDLE;
			return;
		end
		if (c == " ") return;
		v = lx_hex(c);
		if (v < 0) begin
			raise_err(rlt_pkg::E_HEX, p_pos, p_pos + 16'd1, p_line);
			return;
		end
		if (!seen) p_first_c = p_pos;
		if (!p_phase) begin
			p_hnib = 4'(v);
			p_phase = 1'b1;
		end else begin
			push_tok(rlt_pkg::K_HEXBYTE, p_last_c, p_pos + 16'd1, p_line,
				64'({p_hnib, 4'(v)}), rlt_pkg::E_NONE);
			p_phase = 1'b0;
			if (p_bcnt != 16'hffff) p_bcnt++;
		end
		p_last_c = p_pos;
	endtask

	// predicts the tokens of one accepted item and appends them to tokens_due
	task automatic predict_tokens(src_item_t it);
		bit taken, in_sec;
		logic [63:0] d;
		int c;
		step_out.delete();
		taken = 1'b0;
		c = it.c;
		if (it.act == ACT_EOS) begin
			if (!p_halted) begin
				case (p_mode)
					S_OP: push_tok(op_base(), p_tstart, p_tstart + 16'd1, p_line, 64'd0,
						rlt_pkg::E_NONE);
					S_IDENT: dummy = finish_ident(-1);
					S_INT: dummy = finish_int(-1);
					S_SIZEB: raise_err(rlt_pkg::E_SIZE, p_tstart, p_pos, p_line);
					S_STR, S_REGEX, S_HEX: raise_err(rlt_pkg::E_UNTERM, p_tstart, p_pos, p_line);
					default: ;
				endcase
			end
			scanner_clear();
		end else if (!p_halted) begin
			in_sec = (p_mode == S_STR || p_mode == S_REGEX);
			case (p_mode)
				S_OP: begin
					if (c == "=") begin
						push_tok(op_base() + 6'd1, p_tstart, p_pos + 16'd1, p_line, 64'd0,
							rlt_pkg::E_NONE);
						taken = 1'b1;
					end else begin
						push_tok(op_base(), p_tstart, p_tstart + 16'd1, p_line, 64'd0,
							rlt_pkg::E_NONE);
					end
					p_mode = S_IDLE;
				end
				S_IDENT: begin
					if (lx_alpha(it.c) || lx_digit(it.c)) begin
						if (p_ilen < 9) p_kw[p_ilen] = it.c;
						if (p_ilen < 10) p_ilen++;
						taken = 1'b1;
					end else begin
						taken = finish_ident(c);
						p_mode = S_IDLE;
					end
				end
				S_INT: begin
					if (lx_digit(it.c)) begin
						d = 64'(c - "0");
						if (p_acc > (64'hffff_ffff_ffff_ffff - d) / 10) p_acc = '1;
						else p_acc = p_acc * 10 + d;
						if (p_dcnt < rlt_pkg::SIZE_DIGITS_MAX) begin
							p_sdig = p_sdig * 10 + d;
							p_dcnt++;
						end
						taken = 1'b1;
					end else begin
						taken = finish_int(c);
					end
				end
				S_SIZEB: begin
					if (c == "B" || c == "b") begin
						push_tok(rlt_pkg::K_INTEGER, p_tstart, p_pos + 16'd1, p_line,
							p_sdig << (10 * p_letter), rlt_pkg::E_NONE);
						p_mode = S_IDLE;
					end else begin
						raise_err(rlt_pkg::E_SIZE, p_tstart, p_pos, p_line);
					end
					taken = 1'b1;
				end
				S_STR: begin
					if (c == "\"" && p_prev != "\\") begin
						push_tok(rlt_pkg::K_STRING, p_tstart + 16'd1, p_pos, p_line, 64'd0,
							rlt_pkg::E_NONE);
						p_mode = S_IDLE;
					end else if (c == 8'h0a) begin
						raise_err(rlt_pkg::E_SPANS_LINE, p_tstart, p_pos, p_sec_line);
					end
					taken = 1'b1;
				end
				S_REGEX: begin
					if (c == "/" && p_prev != "\\") begin
						push_tok(rlt_pkg::K_REGEXP, p_tstart, p_pos + 16'd1, p_line, 64'd0,
							rlt_pkg::E_NONE);
						p_mode = S_IDLE;
					end else if (c == 8'h0a) begin
						p_line = p_line + 16'd1;
					end
					taken = 1'b1;
				end
				S_HEX: begin
					hex_char(it.c);
					taken = 1'b1;
				end
				default: ;
			endcase
			if (!taken && !p_halted) idle_char(it.c);
			if (!p_halted) begin
				if (in_sec && c == "\\" && p_prev == "\\") p_prev = '0;
				else p_prev = it.c;
				p_pos = p_pos + 16'd1;
			end
		end
		if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
		foreach (step_out[i]) tokens_due.insert(tokens_due.size(), step_out[i]);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_tokens('{act: action, c: ch});
				accepted++;
			end
			if (!(in_valid && !in_ready)) begin
				if (src_pending.size() > 0 && !hold_sender &&
						(idle_free || $urandom_range(99) >= 22)) begin
					in_valid <= 1'b1;
					action <= src_pending[0].act;
					ch <= src_pending[0].c;
					src_pending.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= idle_free || $urandom_range(99) >= 22;
		end
	end

	// monitor
	always @(posedge clk) begin
		rlt_pkg::result_t got, want;
		cycles++;
		if (arst_n && out_valid && out_ready) begin
			got.kind = kind; got.start_pos = start_pos; got.end_pos = end_pos;
			got.line_number = line_number; got.value = value; got.error_code = error_code;
			got.last = last;
			tokens_seen++;
			if (kind == rlt_pkg::K_ERROR) errors_seen++;
			if (tokens_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected token kind=%0d", kind);
			end else begin
				want = tokens_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp k=%0d s=%0d e=%0d ln=%0d v=%0h err=%0d l=%0b | got k=%0d s=%0d e=%0d ln=%0d v=%0h err=%0d l=%0b",
							want.kind, want.start_pos, want.end_pos, want.line_number,
							want.value, want.error_code, want.last, got.kind, got.start_pos,
							got.end_pos, got.line_number, got.value, got.error_code, got.last);
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("[rule_language_tokenizer] ERROR");
			$finish;
		end
	end

	task automatic add_text(string s);
		foreach (s[i]) src_pending.insert(src_pending.size(), '{act: ACT_CHAR, c: s[i]});
	endtask

	task automatic add_eos();
		src_pending.insert(src_pending.size(), '{act: ACT_EOS, c: 8'($urandom)});
	endtask

	task automatic drain();
		while (src_pending.size() > 0 || in_valid) @(posedge clk);
		while (tokens_due.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_first_line(logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		p_first_line = v;
		p_line = v;
	endtask

	function automatic string rnd_word();
		string pool[20] = '{"rule", "meta", "condition", "content", "and", "or", "nocase",
			"ascii", "wide", "of", "them", "any", "all", "at", "foo", "x_1", "Abcdefghijk",
			"_z9", "rules", "at2"};
		return pool[$urandom_range(19)];
	endfunction

	// one well-formed token text, random content
	function automatic string rnd_token();
		string s;
		int n;
		case ($urandom_range(15))
			0: s = rnd_word();
			1: s = {"$", rnd_word()};
			2: s = {rnd_word(), "*"};
			3: begin
				s = "";
				n = $urandom_range(1, 22);
				repeat (n) s = {s, string'(8'("0" + $urandom_range(9)))};
			end
			4: begin
				s = $sformatf("%0d", $urandom_range(9999));
				case ($urandom_range(3))
					0: s = {s, "B"};
					1: s = {s, "kb"};
					2: s = {s, "Mb"};
					default: s = {s, "GB"};
				endcase
			end
			5: s = "\"ab\\\"c\\\\\"";
			6: s = "/a\\/b\n/";
			7: begin
				s = "| ";
				n = $urandom_range(0, 6);
				repeat (n) s = {s, $sformatf("%02X ", $urandom_range(255))};
				if ($urandom_range(3) == 0) s = {s, "f"};
				s = {s, "|"};
			end
			8: s = "==";
			9: s = "<=";
			10: s = ">=";
			11: s = "=";
			12: s = "\n";
			13: s = "(){}:";
			14: s = {"\"", rnd_word(), "\""};
			default: s = "$";
		endcase
		return s;
	endfunction

	function automatic string rnd_sep();
		case ($urandom_range(5))
			0: return "";
			1: return "\t";
			2: return "\n";
			3: return "\r";
			default: return " ";
		endcase
	endfunction

	initial begin
		int n;
		string s;
		p_first_line = 16'd1;
		scanner_clear();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every token class and error, at reset line number
		add_text("$a rule $them x* 12 3kb 4MB 5gb 7b ( ) { } : * == = <= < >= > ");
		add_text("\"s\\\"q\\\\\" /r\\/\n/ | 0a Ff 1 | || 99999999999999999999999 ");
		add_eos();
		add_text("12x"); add_eos();
		add_text("5k "); add_eos();
		add_text("\"ab\ncd\""); add_eos();
		add_text("|0g|"); add_eos();
		add_text({"a ", string'(8'hff), " b"}); add_eos();
		add_text("\"open"); add_eos();
		add_text("| 12"); add_eos();
		add_text("/re"); add_eos();
		add_text("abc"); add_eos();
		add_text("<"); add_eos();
		add_text("77"); add_eos();
		add_text("3M"); add_eos();
		add_eos();
		drain();

		write_first_line(16'hffff);
		add_text("a\nb\n\"x\ny"); add_eos();
		drain();
		write_first_line(16'd0);
		add_text("rule q { condition : $a }\n"); add_eos();
		drain();
		write_first_line(16'd1);

		for (int blk = 0; blk < 36; blk++) begin
			idle_free = (blk >= 12 && blk < 18);
			if (blk == 18) begin
				drain();
				write_first_line(16'($urandom));
			end
			n = $urandom_range(3, 12);
			repeat (n) begin
				s = {rnd_token(), rnd_sep()};
				if (s.len() > 0 && s[s.len() - 1] != " " && $urandom_range(2) == 0) s = {s, " "};
				add_text(s);
			end
			// noise: any byte value
			if ($urandom_range(4) == 0)
				src_pending.insert(src_pending.size(), '{act: ACT_CHAR, c: 8'($urandom)});
			if ($urandom_range(9) == 0) add_text("12q");
			add_eos();
		end
		// random raw bytes so every bit of ch toggles
		repeat (100) src_pending.insert(src_pending.size(), '{act: ACT_CHAR, c: 8'($urandom)});
		add_eos();

		// pause sender until the output side has caught up
		while (src_pending.size() > 200) @(posedge clk);
		hold_sender = 1'b1;
		while (in_valid) @(posedge clk);
		while (tokens_due.size() > 0) @(posedge clk);
		hold_sender = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		$display("items accepted: %0d, tokens checked: %0d, error tokens: %0d",
			accepted, tokens_seen, errors_seen);
		if (mismatches == 0 && tokens_due.size() == 0) begin
			$display("[rule_language_tokenizer] OK");
		end else begin
			$display("[rule_language_tokenizer] ERROR");
		end
		$finish;
	end
endmodule
